// ----- sv/ple_pkg.sv -----
// Shared types and codes for the positional list engine.
// Depends on nothing; used by ple_cell and positional_list_engine.
`timescale 1ns / 1ps
`default_nettype none

package ple_pkg;

  // item command codes
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_DELETE = 1'b1;

  // result status codes
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_RANGE = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  // fixed field widths
  localparam int POS_W = 5;
  localparam int VAL_W = 32;
  localparam int LEN_W = 5;

  typedef logic signed [VAL_W-1:0] value_t;
  typedef logic [POS_W-1:0]        pos_t;

  // shift control broadcast to every cell
  typedef struct packed {
    logic ins_en;
    logic del_en;
    pos_t pos;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ----- sv/ple_cell.sv -----
// One list slot: holds a single entry and shifts with its neighbors.
// Depends on ple_pkg for the value type and the shift control struct.
`timescale 1ns / 1ps
`default_nettype none

module ple_cell #(
  parameter int INDEX = 0
) (
  input  wire                       clk,
  input  wire ple_pkg::cell_ctrl_t  ctrl,
  input  wire ple_pkg::value_t      new_value,
  input  wire ple_pkg::value_t      prev_value,
  input  wire ple_pkg::value_t      next_value,
  output ple_pkg::value_t           value,
  output ple_pkg::value_t           hit_value
);

  // 1-based position of this slot
  localparam logic [31:0] SLOT = 32'(INDEX + 1);

  ple_pkg::value_t entry_r;
  ple_pkg::value_t entry_nxt;
  logic [31:0]     pos_ext;
  logic            at_pos;
  logic            after_pos;

  assign pos_ext   = {{(32 - ple_pkg::POS_W){1'b0}}, ctrl.pos};
  assign at_pos    = (SLOT == pos_ext);
  assign after_pos = (SLOT > pos_ext);

  // insert loads here or takes the left neighbor; delete takes the right one
  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.ins_en) begin
      if (at_pos) begin
        entry_nxt = new_value;
      end else if (after_pos) begin
        entry_nxt = prev_value;
      end
    end else if (ctrl.del_en) begin
      if (at_pos || after_pos) begin
        entry_nxt = next_value;
      end
    end
  end

  // entry storage, no reset
  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign value     = entry_r;
  // contributes to the removed-value or-reduction only at the addressed slot
  assign hit_value = at_pos ? entry_r : '0;

endmodule

`default_nettype wire

// ----- sv/positional_list_engine.sv -----
// Top level of the positional list engine: range checks, count and result register.
// Depends on ple_pkg and instantiates a row of ple_cell slots.
`timescale 1ns / 1ps
`default_nettype none

// The engine keeps an ordered list of up to CAPACITY signed 32-bit entries in
// a row of cells, one entry per cell. Every cell shifts in the same clock, so
// an insert or delete at any position never holds the engine: busy stays
// low and a new item may be started every cycle. The result (status, removed
// value and new length) appears on the out_ ports in the cycle after the item is
// taken, marked by out_valid for exactly that cycle; the receiver cannot
// stall, so it must capture every result when out_valid is high. The removed
// value is zero for inserts and for any item that fails its position check.
module positional_list_engine #(
  parameter int CAPACITY = 16
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 start,
  output logic                                busy,
  input  wire                                 in_command,
  input  wire  [ple_pkg::POS_W-1:0]           in_position,
  input  wire  signed [ple_pkg::VAL_W-1:0]    in_value,
  output logic                                out_valid,
  output logic [1:0]                          out_status,
  output logic signed [ple_pkg::VAL_W-1:0]    out_removed_value,
  output logic [ple_pkg::LEN_W-1:0]           out_length
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int VW = ((CW > ple_pkg::POS_W) ? CW : ple_pkg::POS_W) + 1;

  logic [CW-1:0]          count_r;
  logic [CW-1:0]          count_nxt;
  logic                   out_valid_r;
  logic [1:0]             out_status_r;
  logic [1:0]             status_nxt;
  ple_pkg::value_t        out_removed_value_r;
  ple_pkg::value_t        removed_nxt;
  logic [ple_pkg::LEN_W-1:0] out_length_r;

  logic                   accept;
  logic [VW-1:0]          pos_ext;
  logic [VW-1:0]          cnt_ext;
  logic [VW-1:0]          cnt_nxt_ext;
  logic                   is_full;
  ple_pkg::cell_ctrl_t    ctrl;
  ple_pkg::value_t        cell_q   [CAPACITY];
  ple_pkg::value_t        cell_hit [CAPACITY];
  ple_pkg::value_t        hit_or;

  // every cell shifts at once: never busy
  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign pos_ext = VW'(in_position);
  assign cnt_ext = VW'(count_r);
  assign is_full = (cnt_ext == VW'(CAPACITY));

  // position checks and status
  always_comb begin
    status_nxt = ple_pkg::STATUS_OK;
    if (in_command == ple_pkg::CMD_INSERT) begin
      if (pos_ext == '0 || pos_ext > cnt_ext + VW'(1)) begin
        status_nxt = ple_pkg::STATUS_RANGE;
      end else if (is_full) begin
        status_nxt = ple_pkg::STATUS_FULL;
      end
    end else begin
      if (pos_ext == '0 || pos_ext > cnt_ext) begin
        status_nxt = ple_pkg::STATUS_RANGE;
      end
    end
  end

  // shift control for the cell row
  always_comb begin
    ctrl.pos    = in_position;
    ctrl.ins_en = accept && (in_command == ple_pkg::CMD_INSERT) &&
                  (status_nxt == ple_pkg::STATUS_OK);
    ctrl.del_en = accept && (in_command == ple_pkg::CMD_DELETE) &&
                  (status_nxt == ple_pkg::STATUS_OK);
  end

  // row of cells, each wired to its neighbors
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    ple_pkg::value_t prev_v;
    ple_pkg::value_t next_v;
    if (i == 0) begin : g_first
      assign prev_v = in_value;
    end else begin : g_mid_prev
      assign prev_v = cell_q[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign next_v = cell_q[i];
    end else begin : g_mid_next
      assign next_v = cell_q[i+1];
    end
    ple_cell #(.INDEX(i)) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .new_value  (in_value),
      .prev_value (prev_v),
      .next_value (next_v),
      .value      (cell_q[i]),
      .hit_value  (cell_hit[i])
    );
  end

  // gather the addressed entry
  always_comb begin
    hit_or = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      hit_or = hit_or | cell_hit[k];
    end
  end

  // next count and removed value
  always_comb begin
    count_nxt   = count_r;
    removed_nxt = '0;
    if (ctrl.ins_en) begin
      count_nxt = count_r + CW'(1);
    end else if (ctrl.del_en) begin
      count_nxt   = count_r - CW'(1);
      removed_nxt = hit_or;
    end
  end

  assign cnt_nxt_ext = VW'(count_nxt);

  // count and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= accept;
    end
    if (accept) begin
      out_status_r        <= status_nxt;
      out_removed_value_r <= removed_nxt;
      out_length_r        <= cnt_nxt_ext[ple_pkg::LEN_W-1:0];
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_removed_value = out_removed_value_r;
  assign out_length        = out_length_r;

  // every started item yields a result in the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> out_valid)
    else $error("started item produced no result");

  // the list never holds more than its capacity
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_ext <= VW'(CAPACITY))
    else $error("entry count above capacity");

  // a full status only when the list really is full
  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ple_pkg::STATUS_FULL) |-> is_full)
    else $error("full status with free slots");

  // failed items never report a removed value
  a_fail_no_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ple_pkg::STATUS_OK) |-> (out_removed_value == '0))
    else $error("removed value on failed item");

endmodule

`default_nettype wire

// ----- bench/testbench.sv -----
// Self-checking bench for positional_list_engine: directed and random inserts and deletes.
// Depends on ple_pkg and positional_list_engine; an in-bench list model predicts each result.
`timescale 1ns / 1ps

module testbench;

  localparam int LIST_CAP = 16;

  // one expected result
  typedef struct {
    logic [1:0]                status;
    ple_pkg::value_t           removed;
    logic [ple_pkg::LEN_W-1:0] length;
  } list_result_t;

  // list model plus the queue of results still owed by the block
  class list_tracker;
    ple_pkg::value_t  entries[LIST_CAP];
    int unsigned      length = 0;
    list_result_t     pending[$];
    int unsigned      errors = 0;
    int unsigned      checked = 0;
    int unsigned      status_seen[3] = '{0, 0, 0};
    int unsigned      full_hits = 0;

    // apply an accepted item to the model and queue its result
    function void note_item(logic cmd, ple_pkg::pos_t pos, ple_pkg::value_t val);
      list_result_t r;
      int unsigned  k;
      r.status  = ple_pkg::STATUS_OK;
      r.removed = '0;
      if (cmd == ple_pkg::CMD_INSERT) begin
        if (pos < 1 || pos > length + 1) begin
          r.status = ple_pkg::STATUS_RANGE;
        end else if (length >= LIST_CAP) begin
          r.status = ple_pkg::STATUS_FULL;
        end else begin
          for (k = length; k >= pos; k--) entries[k] = entries[k-1];
          entries[pos-1] = val;
          length++;
          if (length == LIST_CAP) full_hits++;
        end
      end else begin
        if (pos < 1 || pos > length) begin
          r.status = ple_pkg::STATUS_RANGE;
        end else begin
          r.removed = entries[pos-1];
          for (k = pos; k < length; k++) entries[k-1] = entries[k];
          length--;
        end
      end
      r.length = ple_pkg::LEN_W'(length);
      pending.push_back(r);
    endfunction

    function void flag(string field, logic [31:0] want, logic [31:0] got);
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
      errors++;
    endfunction

    // compare one result from the block with the oldest expectation
    function void check_result(logic [1:0] status, ple_pkg::value_t removed,
                               logic [ple_pkg::LEN_W-1:0] len);
      list_result_t exp;
      if (pending.size() == 0) begin
        $display("%0t: result with no item outstanding, status %0h removed %0h length %0h",
                 $time, status, removed, len);
        errors++;
        return;
      end
      exp = pending.pop_front();
      checked++;
      status_seen[exp.status]++;
      if (status !== exp.status) flag("status", exp.status, status);
      if (removed !== exp.removed) flag("removed_value", exp.removed, removed);
      if (len !== exp.length) flag("length", exp.length, len);
    endfunction
  endclass

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           start = 1'b0;
  logic                           in_command = ple_pkg::CMD_INSERT;
  logic [ple_pkg::POS_W-1:0]      in_position = '0;
  logic signed [ple_pkg::VAL_W-1:0] in_value = '0;
  wire                            busy;
  wire                            out_valid;
  wire [1:0]                      out_status;
  wire signed [ple_pkg::VAL_W-1:0] out_removed_value;
  wire [ple_pkg::LEN_W-1:0]       out_length;

  list_tracker tracker = new;
  int unsigned items_sent = 0;
  bit          filling = 1'b1;

  positional_list_engine #(.CAPACITY(LIST_CAP)) u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_command        (in_command),
    .in_position       (in_position),
    .in_value          (in_value),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_removed_value (out_removed_value),
    .out_length        (out_length)
  );

  always #1 clk = ~clk;

  // results cannot be held off, so every strobe is checked on its edge
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1)
      tracker.check_result(out_status, out_removed_value, out_length);
  end

  // present one item, with random idle cycles in front, and wait for acceptance
  task automatic send_item(logic cmd, ple_pkg::pos_t pos, ple_pkg::value_t val,
                           int unsigned idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start       <= 1'b1;
    in_command  <= cmd;
    in_position <= pos;
    in_value    <= val;
    do @(posedge clk); while (busy);
    tracker.note_item(cmd, pos, val);
    items_sent++;
  endtask

  // hold off until every queued result has come back
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (tracker.pending.size() != 0);
  endtask

  // edges of the position range, both ends of the list, full and empty
  task automatic run_directed();
    send_item(ple_pkg::CMD_DELETE, 1, $urandom, 0);
    send_item(ple_pkg::CMD_INSERT, 0, $urandom, 0);
    send_item(ple_pkg::CMD_INSERT, 2, $urandom, 0);
    send_item(ple_pkg::CMD_INSERT, 1, 32'sh7fffffff, 0);
    send_item(ple_pkg::CMD_INSERT, 1, 32'sh80000000, 0);
    send_item(ple_pkg::CMD_INSERT, 3, -32'sd1, 0);
    send_item(ple_pkg::CMD_INSERT, 2, 32'sd0, 0);
    send_item(ple_pkg::CMD_DELETE, 0, $urandom, 0);
    send_item(ple_pkg::CMD_DELETE, 5, $urandom, 0);
    send_item(ple_pkg::CMD_DELETE, 2, $urandom, 0);
    while (tracker.length < LIST_CAP)
      send_item(ple_pkg::CMD_INSERT,
                ple_pkg::pos_t'($urandom_range(tracker.length + 1, 1)), $urandom, 0);
    send_item(ple_pkg::CMD_INSERT, 17, $urandom, 0);
    send_item(ple_pkg::CMD_INSERT, 18, $urandom, 0);
    send_item(ple_pkg::CMD_DELETE, 16, $urandom, 0);
    send_item(ple_pkg::CMD_DELETE, 31, $urandom, 0);
    send_item(ple_pkg::CMD_INSERT, 31, $urandom, 0);
  endtask

  // mostly legal items that sweep the list between empty and full, some noise
  task automatic run_random(int unsigned n, int unsigned idle_pct);
    logic          cmd;
    ple_pkg::pos_t pos;
    int unsigned   len;
    int unsigned   top;
    repeat (n) begin
      len = tracker.length;
      if ($urandom_range(9) == 0) begin
        cmd = 1'($urandom_range(1));
        pos = ple_pkg::pos_t'($urandom_range(31));
      end else begin
        if (len == LIST_CAP) begin
          cmd     = filling ? ple_pkg::CMD_INSERT : ple_pkg::CMD_DELETE;
          filling = 1'b0;
        end else if (len == 0) begin
          cmd     = ple_pkg::CMD_INSERT;
          filling = 1'b1;
        end else begin
          cmd = ($urandom_range(99) < (filling ? 70 : 30)) ?
                ple_pkg::CMD_INSERT : ple_pkg::CMD_DELETE;
        end
        top = (cmd == ple_pkg::CMD_INSERT) ? len + 1 : len;
        case ($urandom_range(3))
          0:       pos = 1;
          1:       pos = ple_pkg::pos_t'(top);
          default: pos = ple_pkg::pos_t'($urandom_range(top, 1));
        endcase
      end
      send_item(cmd, pos, $urandom, idle_pct);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    drain();
    run_random(470, 19);
    drain();
    run_random(470, 88);
    drain();
    run_random(470, 0);
    drain();
    repeat (4) @(posedge clk);
    $display("%0d items sent, %0d results checked (ok %0d, range %0d, full %0d)",
             items_sent, tracker.checked, tracker.status_seen[ple_pkg::STATUS_OK],
             tracker.status_seen[ple_pkg::STATUS_RANGE],
             tracker.status_seen[ple_pkg::STATUS_FULL]);
    $display("list filled to capacity %0d times, %0d mismatches", tracker.full_hits,
             tracker.errors);
    if (tracker.errors == 0)
      $display("** positional_list_engine: PASSED **");
    else
      $display("** positional_list_engine: FAILED **");
    $finish;
  end

  // watchdog
  initial begin
    #1000000;
    $display("timeout with %0d results outstanding", tracker.pending.size());
    $display("** positional_list_engine: FAILED **");
    $finish;
  end

endmodule
